[rtl/kci_pkg.sv]
// Shared types and constants of the keyframe color interpolator.
// Used by kci_ctrl, kci_dpath and the top level; depends on nothing.
package kci_pkg;

    localparam int MAX_KEYS_DEF   = 16;
    localparam int FRAME_BITS_DEF = 16;

    localparam int COLOR_BITS = 24;
    localparam int CHANNELS   = 3;
    localparam int LEVEL_BITS = 8;
    localparam int QUOT_BITS  = 11;
    localparam int QUOT_SHIFT = QUOT_BITS - 1;
    localparam int CNT_BITS   = $clog2(QUOT_BITS);

    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 16;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_KEY_COUNT    = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_REPEAT_COUNT = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_LOOP_FOREVER = 2'd2;

    localparam logic [1:0] FUNC_LOAD    = 2'd0;
    localparam logic [1:0] FUNC_ADVANCE = 2'd1;
    localparam logic [1:0] FUNC_QUERY   = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ADV,
        ST_PROBE,
        ST_CMP,
        ST_CLAMP,
        ST_PREV,
        ST_NEXT,
        ST_MUL,
        ST_DIV,
        ST_FIN
    } state_t;

    typedef enum logic [2:0] {
        ADDR_LAST,
        ADDR_MID,
        ADDR_ZERO,
        ADDR_HIGH,
        ADDR_LOW
    } addr_sel_t;

    typedef enum logic {
        EMIT_RAM,
        EMIT_INTERP
    } emit_sel_t;

    typedef struct packed {
        logic      load;
        logic      ld_query;
        logic      adv_step;
        addr_sel_t rd_sel;
        logic      probe;
        logic      narrow;
        logic      latch_prev;
        logic      latch_next;
        logic      mul;
        logic      div_step;
        logic      emit;
        emit_sel_t emit_sel;
    } cmd_t;

    typedef struct packed {
        logic search_open;
        logic below_first;
        logic past_last;
        logic hit;
        logic div_last;
    } status_t;

endpackage

[rtl/kci_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; no package dependency.
module kci_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/kci_ctrl.sv]
// Sequencer of the keyframe color interpolator: issues datapath commands.
// Depends on kci_pkg (state_t, cmd_t, status_t, func codes).
module kci_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [1:0]       func,
    input  kci_pkg::status_t status,
    output logic             busy,
    output kci_pkg::cmd_t    cmd
);

    kci_pkg::state_t state_reg;
    kci_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= kci_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        cmd.rd_sel   = kci_pkg::ADDR_LAST;
        cmd.emit_sel = kci_pkg::EMIT_RAM;
        busy         = (state_reg != kci_pkg::ST_IDLE);

        unique case (state_reg)
            kci_pkg::ST_IDLE:
            begin
                // read of the last key is issued here so advance has it next cycle
                if (start)
                begin
                    priority if (func == kci_pkg::FUNC_LOAD)
                    begin
                        cmd.load = 1'b1;
                    end
                    else if (func == kci_pkg::FUNC_ADVANCE)
                    begin
                        state_next = kci_pkg::ST_ADV;
                    end
                    else if (func == kci_pkg::FUNC_QUERY)
                    begin
                        cmd.ld_query = 1'b1;
                        state_next   = kci_pkg::ST_PROBE;
                    end
                    else
                    begin
                        state_next = kci_pkg::ST_IDLE;
                    end
                end
            end
            kci_pkg::ST_ADV:
            begin
                cmd.adv_step = 1'b1;
                state_next   = kci_pkg::ST_PROBE;
            end
            kci_pkg::ST_PROBE:
            begin
                priority if (status.search_open)
                begin
                    cmd.rd_sel = kci_pkg::ADDR_MID;
                    cmd.probe  = 1'b1;
                    state_next = kci_pkg::ST_CMP;
                end
                else if (status.below_first)
                begin
                    cmd.rd_sel = kci_pkg::ADDR_ZERO;
                    state_next = kci_pkg::ST_CLAMP;
                end
                else if (status.past_last)
                begin
                    cmd.rd_sel = kci_pkg::ADDR_LAST;
                    state_next = kci_pkg::ST_CLAMP;
                end
                else
                begin
                    cmd.rd_sel = kci_pkg::ADDR_HIGH;
                    state_next = kci_pkg::ST_PREV;
                end
            end
            kci_pkg::ST_CMP:
            begin
                if (status.hit)
                begin
                    cmd.emit   = 1'b1;
                    state_next = kci_pkg::ST_IDLE;
                end
                else
                begin
                    cmd.narrow = 1'b1;
                    state_next = kci_pkg::ST_PROBE;
                end
            end
            kci_pkg::ST_CLAMP:
            begin
                cmd.emit   = 1'b1;
                state_next = kci_pkg::ST_IDLE;
            end
            kci_pkg::ST_PREV:
            begin
                cmd.latch_prev = 1'b1;
                cmd.rd_sel     = kci_pkg::ADDR_LOW;
                state_next     = kci_pkg::ST_NEXT;
            end
            kci_pkg::ST_NEXT:
            begin
                cmd.latch_next = 1'b1;
                state_next     = kci_pkg::ST_MUL;
            end
            kci_pkg::ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = kci_pkg::ST_DIV;
            end
            kci_pkg::ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = kci_pkg::ST_FIN;
                end
            end
            kci_pkg::ST_FIN:
            begin
                cmd.emit     = 1'b1;
                cmd.emit_sel = kci_pkg::EMIT_INTERP;
                state_next   = kci_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = kci_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

[rtl/kci_dpath.sv]
// Datapath of the keyframe color interpolator: key table, configuration,
// search bounds, three-lane multiply and restoring divide, result registers.
// Depends on kci_pkg and kci_ram.
module kci_dpath #(
    parameter int MAX_KEYS   = kci_pkg::MAX_KEYS_DEF,
    parameter int FRAME_BITS = kci_pkg::FRAME_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  kci_pkg::cmd_t                      cmd,
    output kci_pkg::status_t                   status,
    input  logic                               cfg_we,
    input  logic [kci_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [kci_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    input  logic [3:0]                         key_index,
    input  logic [15:0]                        key_frame_number,
    input  logic [7:0]                         key_red,
    input  logic [7:0]                         key_green,
    input  logic [7:0]                         key_blue,
    input  logic [15:0]                        query_frame,
    output logic                               done,
    output logic [15:0]                        shown_frame,
    output logic [7:0]                         red,
    output logic [7:0]                         green,
    output logic [7:0]                         blue,
    output logic [15:0]                        next_position
);

    localparam int AW  = $clog2(MAX_KEYS);
    localparam int NW  = $clog2(MAX_KEYS + 1);
    localparam int SW  = NW + 1;
    localparam int FW  = FRAME_BITS;
    localparam int CB  = kci_pkg::COLOR_BITS;
    localparam int EW  = FW + CB;
    localparam int LB  = kci_pkg::LEVEL_BITS;
    localparam int MW  = FW + LB;
    localparam int DW  = FW + kci_pkg::QUOT_SHIFT;
    localparam int QW  = kci_pkg::QUOT_BITS;
    localparam int CH  = kci_pkg::CHANNELS;
    localparam int CW  = kci_pkg::CNT_BITS;
    localparam int RW  = LB + 4;

    // configuration and animation state
    logic [4:0]              key_count_reg, key_count_next;
    logic                    loop_reg, loop_next;
    logic [16:0]             passes_reg, passes_next;
    logic [FW-1:0]           pos_reg, pos_next;

    // item in flight
    logic [FW-1:0]           num_reg, num_next;
    logic [FW-1:0]           shown_reg, shown_next;
    logic [FW-1:0]           nextp_reg, nextp_next;
    logic signed [SW-1:0]    low_reg, low_next;
    logic signed [SW-1:0]    high_reg, high_next;
    logic [AW-1:0]           mid_reg, mid_next;

    // interpolation
    logic [FW-1:0]           pn_reg, pn_next;
    logic [CB-1:0]           pc_reg, pc_next;
    logic [FW-1:0]           s_mag_reg, s_mag_next;
    logic [FW-1:0]           t_mag_reg, t_mag_next;
    logic                    sgn_st_reg, sgn_st_next;
    logic [LB-1:0]           d_mag_reg [CH];
    logic [LB-1:0]           d_mag_next [CH];
    logic                    d_neg_reg [CH];
    logic                    d_neg_next [CH];
    logic [MW-1:0]           rem_reg [CH];
    logic [MW-1:0]           rem_next [CH];
    logic [QW-1:0]           q_reg [CH];
    logic [QW-1:0]           q_next [CH];
    logic [DW-1:0]           dsr_reg, dsr_next;
    logic [CW-1:0]           cnt_reg, cnt_next;

    // results
    logic                    done_reg, done_next;
    logic [15:0]             out_shown_reg, out_shown_next;
    logic [15:0]             out_next_reg, out_next_next;
    logic [CB-1:0]           out_color_reg, out_color_next;

    // table port
    logic                    mem_we;
    logic [AW-1:0]           waddr;
    logic [EW-1:0]           wdata;
    logic [AW-1:0]           raddr;
    logic [EW-1:0]           rdata;
    logic [FW-1:0]           rd_num;
    logic [CB-1:0]           rd_color;

    logic [NW-1:0]           n_keys;
    logic [AW-1:0]           last_addr;
    logic [SW-1:0]           mid_sum;
    logic [AW-1:0]           mid_now;
    logic [CB-1:0]           interp_color;

    kci_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_KEYS)
    ) u_table (
        .clk   (clk),
        .we    (mem_we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign rd_num   = rdata[EW-1:CB];
    assign rd_color = rdata[CB-1:0];

    // keys in use: zero acts as one, the top clamps to the table size
    always_comb
    begin
        if (key_count_reg == 5'd0)
        begin
            n_keys = NW'(1);
        end
        else if (32'(key_count_reg) > MAX_KEYS)
        begin
            n_keys = NW'(MAX_KEYS);
        end
        else
        begin
            n_keys = NW'(key_count_reg);
        end
    end

    assign last_addr = AW'(n_keys - NW'(1));
    assign mid_sum   = low_reg + high_reg;
    assign mid_now   = mid_sum[AW:1];

    assign mem_we = cmd.load && (32'(key_index) < MAX_KEYS);
    assign waddr  = AW'(key_index);
    assign wdata  = {FW'(key_frame_number), key_red, key_green, key_blue};

    always_comb
    begin
        unique case (cmd.rd_sel)
            kci_pkg::ADDR_LAST: raddr = last_addr;
            kci_pkg::ADDR_MID:  raddr = mid_now;
            kci_pkg::ADDR_ZERO: raddr = '0;
            kci_pkg::ADDR_HIGH: raddr = high_reg[AW-1:0];
            kci_pkg::ADDR_LOW:  raddr = low_reg[AW-1:0];
            default:            raddr = last_addr;
        endcase
    end

    assign status.search_open = (low_reg <= high_reg);
    assign status.below_first = high_reg[SW-1];
    assign status.past_last   = (low_reg >= $signed(SW'(n_keys)));
    assign status.hit         = (rd_num == num_reg);
    assign status.div_last    = (cnt_reg == '0);

    // final level per channel: saturate large quotients, clamp to 0..255
    always_comb
    begin
        logic              neg;
        logic [LB-1:0]     pcc;
        logic signed [RW-1:0] qv;
        logic signed [RW-1:0] lvl;
        for (int c = 0; c < CH; c++)
        begin
            neg = d_neg_reg[c] ^ sgn_st_reg;
            pcc = pc_reg[c*LB +: LB];
            qv  = $signed(RW'(q_reg[c][QW-2:0]));
            if (neg)
            begin
                qv = -qv;
            end
            lvl = $signed(RW'(pcc)) + qv;
            if (s_mag_reg == '0)
            begin
                interp_color[c*LB +: LB] = pcc;
            end
            else if (q_reg[c][QW-1])
            begin
                interp_color[c*LB +: LB] = neg ? '0 : '1;
            end
            else if (lvl < 0)
            begin
                interp_color[c*LB +: LB] = '0;
            end
            else if (lvl > $signed(RW'(255)))
            begin
                interp_color[c*LB +: LB] = '1;
            end
            else
            begin
                interp_color[c*LB +: LB] = lvl[LB-1:0];
            end
        end
    end

    always_comb
    begin
        logic [FW:0]   step;
        logic          wrap;
        logic [FW-1:0] newpos;
        logic [FW:0]   s_diff;
        logic [FW:0]   t_diff;
        logic [LB:0]   d_diff;
        logic [DW-1:0] rem_ext;

        key_count_next = key_count_reg;
        loop_next      = loop_reg;
        passes_next    = passes_reg;
        pos_next       = pos_reg;
        num_next       = num_reg;
        shown_next     = shown_reg;
        nextp_next     = nextp_reg;
        low_next       = low_reg;
        high_next      = high_reg;
        mid_next       = mid_reg;
        pn_next        = pn_reg;
        pc_next        = pc_reg;
        s_mag_next     = s_mag_reg;
        t_mag_next     = t_mag_reg;
        sgn_st_next    = sgn_st_reg;
        dsr_next       = dsr_reg;
        cnt_next       = cnt_reg;
        for (int c = 0; c < CH; c++)
        begin
            d_mag_next[c] = d_mag_reg[c];
            d_neg_next[c] = d_neg_reg[c];
            rem_next[c]   = rem_reg[c];
            q_next[c]     = q_reg[c];
        end
        done_next      = cmd.emit;
        out_shown_next = out_shown_reg;
        out_next_next  = out_next_reg;
        out_color_next = out_color_reg;

        step   = {1'b0, pos_reg} + (FW+1)'(1);
        wrap   = (step > {1'b0, rd_num});
        newpos = wrap ? '0 : step[FW-1:0];
        s_diff = {1'b0, rd_num} - {1'b0, pn_reg};
        t_diff = {1'b0, num_reg} - {1'b0, pn_reg};
        d_diff = '0;
        rem_ext = '0;

        if (cfg_we)
        begin
            unique case (cfg_index)
                kci_pkg::CFG_KEY_COUNT:    key_count_next = cfg_data[4:0];
                kci_pkg::CFG_REPEAT_COUNT: passes_next = {1'b0, cfg_data} + 17'd1;
                kci_pkg::CFG_LOOP_FOREVER: loop_next = cfg_data[0];
                default:                   key_count_next = key_count_reg;
            endcase
        end

        if (cmd.ld_query)
        begin
            num_next   = FW'(query_frame);
            shown_next = FW'(query_frame);
            nextp_next = FW'(query_frame);
            low_next   = '0;
            high_next  = $signed(SW'(n_keys)) - $signed(SW'(1));
        end

        // rdata holds the last key here; it sets the animation length
        if (cmd.adv_step)
        begin
            low_next  = '0;
            high_next = $signed(SW'(n_keys)) - $signed(SW'(1));
            if (!loop_reg && passes_reg == '0)
            begin
                num_next   = rd_num;
                shown_next = rd_num;
                nextp_next = rd_num;
            end
            else
            begin
                num_next   = pos_reg;
                shown_next = pos_reg;
                nextp_next = newpos;
                pos_next   = newpos;
                if (wrap && !loop_reg)
                begin
                    passes_next = passes_reg - 17'd1;
                end
            end
        end

        if (cmd.probe)
        begin
            mid_next = mid_now;
        end

        if (cmd.narrow)
        begin
            if (rd_num > num_reg)
            begin
                high_next = $signed(SW'(mid_reg)) - $signed(SW'(1));
            end
            else
            begin
                low_next = $signed(SW'(mid_reg)) + $signed(SW'(1));
            end
        end

        if (cmd.latch_prev)
        begin
            pn_next = rd_num;
            pc_next = rd_color;
        end

        if (cmd.latch_next)
        begin
            s_mag_next  = s_diff[FW] ? FW'(-s_diff) : s_diff[FW-1:0];
            t_mag_next  = t_diff[FW] ? FW'(-t_diff) : t_diff[FW-1:0];
            sgn_st_next = s_diff[FW] ^ t_diff[FW];
            for (int c = 0; c < CH; c++)
            begin
                d_diff        = {1'b0, rd_color[c*LB +: LB]} - {1'b0, pc_reg[c*LB +: LB]};
                d_neg_next[c] = d_diff[LB];
                d_mag_next[c] = d_diff[LB] ? LB'(-d_diff) : d_diff[LB-1:0];
            end
        end

        if (cmd.mul)
        begin
            for (int c = 0; c < CH; c++)
            begin
                rem_next[c] = MW'(d_mag_reg[c]) * MW'(t_mag_reg);
                q_next[c]   = '0;
            end
            dsr_next = {s_mag_reg, {kci_pkg::QUOT_SHIFT{1'b0}}};
            cnt_next = CW'(kci_pkg::QUOT_SHIFT);
        end

        // one quotient bit per lane per cycle, MSB first
        if (cmd.div_step)
        begin
            for (int c = 0; c < CH; c++)
            begin
                rem_ext = DW'(rem_reg[c]);
                if (rem_ext >= dsr_reg)
                begin
                    rem_next[c] = MW'(rem_ext - dsr_reg);
                    q_next[c]   = {q_reg[c][QW-2:0], 1'b1};
                end
                else
                begin
                    q_next[c] = {q_reg[c][QW-2:0], 1'b0};
                end
            end
            dsr_next = dsr_reg >> 1;
            cnt_next = cnt_reg - CW'(1);
        end

        if (cmd.emit)
        begin
            out_shown_next = 16'(shown_reg);
            out_next_next  = 16'(nextp_reg);
            out_color_next = (cmd.emit_sel == kci_pkg::EMIT_INTERP) ? interp_color : rd_color;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_count_reg <= 5'd1;
            loop_reg      <= 1'b1;
            passes_reg    <= 17'd1;
            pos_reg       <= '0;
            low_reg       <= '0;
            high_reg      <= '0;
            cnt_reg       <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            key_count_reg <= key_count_next;
            loop_reg      <= loop_next;
            passes_reg    <= passes_next;
            pos_reg       <= pos_next;
            low_reg       <= low_next;
            high_reg      <= high_next;
            cnt_reg       <= cnt_next;
            done_reg      <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg       <= num_next;
        shown_reg     <= shown_next;
        nextp_reg     <= nextp_next;
        mid_reg       <= mid_next;
        pn_reg        <= pn_next;
        pc_reg        <= pc_next;
        s_mag_reg     <= s_mag_next;
        t_mag_reg     <= t_mag_next;
        sgn_st_reg    <= sgn_st_next;
        dsr_reg       <= dsr_next;
        out_shown_reg <= out_shown_next;
        out_next_reg  <= out_next_next;
        out_color_reg <= out_color_next;
        for (int c = 0; c < CH; c++)
        begin
            d_mag_reg[c] <= d_mag_next[c];
            d_neg_reg[c] <= d_neg_next[c];
            rem_reg[c]   <= rem_next[c];
            q_reg[c]     <= q_next[c];
        end
    end

    assign done          = done_reg;
    assign shown_frame   = out_shown_reg;
    assign next_position = out_next_reg;
    assign red           = out_color_reg[3*LB-1:2*LB];
    assign green         = out_color_reg[2*LB-1:LB];
    assign blue          = out_color_reg[LB-1:0];

endmodule

[rtl/keyframe_color_interpolator_top.sv]
// Keyframe color interpolator: LED animation engine with a keyframe table.
// Command channel: an item is taken on a clock edge with start high and
//   busy low. func selects load (0), advance and render (1), query (2).
// A load beat writes one table slot in that same cycle; busy stays low and
//   no result follows, so loads can go back to back.
// Advance and query beats each give one result beat: done is high for one
//   cycle with shown_frame, red, green, blue and next_position. The receiver
//   cannot stall; results must be taken when done is high.
// Sequence: each probe of the binary search takes ST_PROBE and ST_CMP
//   (registered table read), up to ceil(log2(K+1)) probes for K keys in
//   use, and a last ST_PROBE closes it. An exact hit emits at its probe; a
//   clamp emits the end key from ST_CLAMP; an interpolation goes through
//   operand fetch (ST_PREV, ST_NEXT), multiply (ST_MUL), the divider in
//   ST_DIV, one quotient bit per step for eleven bits, and ST_FIN to emit.
//   An advance first passes ST_ADV.
// busy is high from the accepting edge until the result beat; a new item
//   may be taken in the cycle that done is high.
// Config writes (cfg_valid/cfg_ready) are taken while busy is low.
// Reset clears position, reloads one pass, sets key_count 1, loop_forever 1;
//   the key table holds nothing defined until loaded.
module keyframe_color_interpolator_top #(
    parameter int MAX_KEYS   = kci_pkg::MAX_KEYS_DEF,
    parameter int FRAME_BITS = kci_pkg::FRAME_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [1:0]                         func,
    input  logic [3:0]                         key_index,
    input  logic [15:0]                        key_frame_number,
    input  logic [7:0]                         key_red,
    input  logic [7:0]                         key_green,
    input  logic [7:0]                         key_blue,
    input  logic [15:0]                        query_frame,
    output logic                               done,
    output logic [15:0]                        shown_frame,
    output logic [7:0]                         red,
    output logic [7:0]                         green,
    output logic [7:0]                         blue,
    output logic [15:0]                        next_position,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [kci_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [kci_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

    kci_pkg::cmd_t    cmd;
    kci_pkg::status_t status;
    logic             cfg_we;

    assign cfg_ready = ~busy;
    assign cfg_we    = cfg_valid & cfg_ready;

    kci_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .func   (func),
        .status (status),
        .busy   (busy),
        .cmd    (cmd)
    );

    kci_dpath #(
        .MAX_KEYS   (MAX_KEYS),
        .FRAME_BITS (FRAME_BITS)
    ) u_dpath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .status           (status),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .key_index        (key_index),
        .key_frame_number (key_frame_number),
        .key_red          (key_red),
        .key_green        (key_green),
        .key_blue         (key_blue),
        .query_frame      (query_frame),
        .done             (done),
        .shown_frame      (shown_frame),
        .red              (red),
        .green            (green),
        .blue             (blue),
        .next_position    (next_position)
    );

endmodule
